>>> src/fir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_pkg - shared types and constants for the 31-tap FIR filter
// Coefficient table, fixed widths, register indexes and the control
// interface between the FIR controller and datapath.
// ----------------------------------------------------------------------------
package fir_pkg;

    // Default sizes
    localparam int DEF_TAPS         = 31;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_COEF_WIDTH   = 16;

    // Fixed widths
    localparam int GAIN_W     = 16;   // Q8.8 gains
    localparam int GAIN_FRAC  = 8;
    localparam int ACC_W      = 40;   // saturating accumulator
    localparam int ACC_LO_W   = 20;   // output gain multiply is split at this bit
    localparam int CFG_IDX_W  = 2;

    localparam logic signed [63:0] ACC_MAX = 64'sd549755813887;
    localparam logic signed [63:0] ACC_MIN = -ACC_MAX - 64'sd1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 2'd1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    // Q1.15 filter taps
    localparam int NUM_COEFS = 31;
    localparam int COEF_Q15 [NUM_COEFS] = '{
        16, 187, 2, 169, 685, -609, -2570, -458, 3137, 1641, -537, 1632, -672,
        -8234, -4187, 9879, 9879, -4187, -8234, -672, 1632, -537, 1641, 3137,
        -458, -2570, -609, 685, 169, 2, 187
    };

    // Coefficient i rescaled to cw bits (round half up when narrowing).
    // Taps past the table are zero.
    function automatic int coef_val(input int idx, input int cw);
        int c;
        if (idx < 0 || idx >= NUM_COEFS) begin
            return 0;
        end
        c = COEF_Q15[idx];
        if (cw >= 16) begin
            return c <<< (cw - 16);
        end
        return (c + (1 <<< (15 - cw))) >>> (16 - cw);
    endfunction

    // Controller -> datapath
    typedef struct packed {
        logic capture;   // latch input sample, step write pointer
        logic gain_mul;  // sample * input gain
        logic store;     // write scaled sample, clear accumulator
        logic rd_en;     // fetch next delay line entry for MAC
        logic clamp;     // saturate accumulator to 40 bits
        logic og_lo;     // low half times output gain
        logic og_hi;     // high half times output gain
        logic sum;       // combine partial products, add rounding
        logic out_load;  // load result register
    } fir_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;  // result register empty or draining this cycle
    } fir_sts_t;

endpackage

`default_nettype wire

>>> src/fir_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/fir_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_ctrl - FIR sequencer
// Steps one sample through input scaling, the tap MAC loop, output scaling
// and the hand-off to the result register.
// ----------------------------------------------------------------------------
module fir_ctrl
    import fir_pkg::*;
#(
    parameter int TAPS = DEF_TAPS
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output      logic     s_ready,
    input  wire fir_sts_t sts,
    output      fir_cmd_t cmd
);

    localparam int CNT_W = $clog2(TAPS + 2);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(TAPS + 1);
    localparam logic [CNT_W-1:0] CNT_TAPS  = CNT_W'(TAPS);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_GAIN  = 9'b000000010,
        S_STORE = 9'b000000100,
        S_MAC   = 9'b000001000,
        S_CLAMP = 9'b000010000,
        S_OLO   = 9'b000100000,
        S_OHI   = 9'b001000000,
        S_SUM   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN: begin
                cmd.gain_mul = 1'b1;
                state_next   = S_STORE;
            end
            S_STORE: begin
                cmd.store  = 1'b1;
                cnt_next   = '0;
                state_next = S_MAC;
            end
            S_MAC: begin
                // reads while the count is below TAPS, then runs on to TAPS + 1 to drain mult/acc
                cmd.rd_en = (cnt_reg < CNT_TAPS);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = S_OLO;
            end
            S_OLO: begin
                cmd.og_lo  = 1'b1;
                state_next = S_OHI;
            end
            S_OHI: begin
                cmd.og_hi  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> src/fir_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_dp - FIR datapath
// Gain registers, delay line RAM with valid bits, one MAC unit, split output
// gain multiply, rounding/saturation and the result register.
// ----------------------------------------------------------------------------
module fir_dp
    import fir_pkg::*;
#(
    parameter int TAPS         = DEF_TAPS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [GAIN_W-1:0]              cfg_wdata,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample_in,
    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output      logic signed [SAMPLE_WIDTH-1:0] m_sample_out,
    input  wire fir_cmd_t                       cmd,
    output      fir_sts_t                       sts
);

    localparam int S      = SAMPLE_WIDTH;
    localparam int C      = COEF_WIDTH;
    localparam int PTR_W  = $clog2(TAPS);
    localparam int GP_W   = S + GAIN_W + 1;           // sample * input gain
    localparam int GR_W   = GP_W + 1;
    localparam int MP_W   = S + C;                    // tap product
    localparam int SUM_W  = S + C + $clog2(TAPS);     // exact tap sum
    localparam int CMP_W  = (SUM_W > ACC_W) ? SUM_W : ACC_W;
    localparam int OP_W   = ACC_LO_W + 1 + GAIN_W + 1;
    localparam int Y_W    = ACC_W + GAIN_W + 1;
    localparam int OSHIFT = C - 1 + GAIN_FRAC;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAPS - 1);

    localparam logic signed [GR_W-1:0] IN_HALF  = GR_W'(1 <<< (GAIN_FRAC - 1));
    localparam logic signed [GR_W-1:0] IN_SMAX  = GR_W'((1 <<< (S - 1)) - 1);
    localparam logic signed [GR_W-1:0] IN_SMIN  = -IN_SMAX - GR_W'(1);
    localparam logic signed [Y_W-1:0]  OUT_HALF = Y_W'(64'sd1 <<< (OSHIFT - 1));
    localparam logic signed [Y_W-1:0]  OUT_SMAX = Y_W'((1 <<< (S - 1)) - 1);
    localparam logic signed [Y_W-1:0]  OUT_SMIN = -OUT_SMAX - Y_W'(1);
    localparam logic signed [CMP_W-1:0] CLAMP_HI = CMP_W'(ACC_MAX);
    localparam logic signed [CMP_W-1:0] CLAMP_LO = CMP_W'(ACC_MIN);

    // configuration
    logic [GAIN_W-1:0] in_gain_reg, out_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_gain_reg  <= GAIN_RESET;
            out_gain_reg <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_INPUT_GAIN:  in_gain_reg  <= cfg_wdata;
                REG_OUTPUT_GAIN: out_gain_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input scaling
    logic signed [S-1:0]    samp_reg;
    logic signed [GP_W-1:0] gprod_reg;
    logic signed [GR_W-1:0] g_round;
    logic signed [S-1:0]    g_sat;
    logic [PTR_W-1:0]       wp_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            samp_reg <= s_sample_in;
        end
        if (cmd.gain_mul) begin
            gprod_reg <= samp_reg * $signed({1'b0, in_gain_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
        end else if (cmd.capture) begin
            wp_reg <= (wp_reg == '0) ? PTR_LAST : wp_reg - 1'b1;
        end
    end

    always_comb begin
        g_round = (GR_W'(gprod_reg) + IN_HALF) >>> GAIN_FRAC;
        if (g_round > IN_SMAX) begin
            g_sat = S'(IN_SMAX);
        end else if (g_round < IN_SMIN) begin
            g_sat = S'(IN_SMIN);
        end else begin
            g_sat = S'(g_round);
        end
    end

    // delay line: RAM plus per-entry valid bits (unwritten entries read as zero)
    logic [TAPS-1:0]  vld_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] tap_reg, tap_d_reg;
    logic             rd_vld_reg, ent_vld_reg;
    logic [S-1:0]     ram_rdata;

    fir_ram #(
        .WIDTH (S),
        .DEPTH (TAPS)
    ) u_delay_ram (
        .clk   (aclk),
        .we    (cmd.store),
        .waddr (wp_reg),
        .wdata (g_sat),
        .re    (cmd.rd_en),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (cmd.store) begin
            vld_reg[wp_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            rd_ptr_reg <= wp_reg;
            tap_reg    <= '0;
        end else if (cmd.rd_en) begin
            rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            tap_reg    <= tap_reg + 1'b1;
        end
        if (cmd.rd_en) begin
            ent_vld_reg <= vld_reg[rd_ptr_reg];
            tap_d_reg   <= tap_reg;
        end
    end

    // MAC: read -> multiply -> accumulate
    logic signed [C-1:0]     coef;
    logic signed [S-1:0]     tap_data;
    logic signed [MP_W-1:0]  prod_reg;
    logic                    prod_vld_reg;
    logic signed [SUM_W-1:0] acc_reg;

    assign coef     = C'(coef_val(int'(tap_d_reg), C));
    assign tap_data = ent_vld_reg ? $signed(ram_rdata) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            prod_reg <= tap_data * coef;
        end
        if (cmd.store) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end
    end

    // clamp to 40 bits, then output gain in two halves
    logic signed [CMP_W-1:0]  acc_ext;
    logic signed [ACC_W-1:0]  acc40_reg;
    logic signed [ACC_LO_W:0] op_a;
    logic signed [OP_W-1:0]   op_p;
    logic signed [OP_W-1:0]   lo_p_reg, hi_p_reg;
    logic signed [Y_W-1:0]    y_reg;
    logic signed [Y_W-1:0]    y_shift;
    logic signed [S-1:0]      y_sat;

    assign acc_ext = CMP_W'(acc_reg);

    always_ff @(posedge aclk) begin
        if (cmd.clamp) begin
            if (acc_ext > CLAMP_HI) begin
                acc40_reg <= ACC_W'(CLAMP_HI);
            end else if (acc_ext < CLAMP_LO) begin
                acc40_reg <= ACC_W'(CLAMP_LO);
            end else begin
                acc40_reg <= ACC_W'(acc_ext);
            end
        end
    end

    // low half is unsigned, high half carries the sign
    assign op_a = cmd.og_hi
                ? $signed({acc40_reg[ACC_W-1], acc40_reg[ACC_W-1:ACC_LO_W]})
                : $signed({1'b0, acc40_reg[ACC_LO_W-1:0]});
    assign op_p = OP_W'(op_a * $signed({1'b0, out_gain_reg}));

    always_ff @(posedge aclk) begin
        if (cmd.og_lo) begin
            lo_p_reg <= op_p;
        end
        if (cmd.og_hi) begin
            hi_p_reg <= op_p;
        end
        if (cmd.sum) begin
            y_reg <= (Y_W'(hi_p_reg) <<< ACC_LO_W) + Y_W'(lo_p_reg) + OUT_HALF;
        end
    end

    always_comb begin
        y_shift = y_reg >>> OSHIFT;
        if (y_shift > OUT_SMAX) begin
            y_sat = S'(OUT_SMAX);
        end else if (y_shift < OUT_SMIN) begin
            y_sat = S'(OUT_SMIN);
        end else begin
            y_sat = S'(y_shift);
        end
    end

    // result register
    logic                m_valid_reg;
    logic signed [S-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= y_sat;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_data_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

>>> src/fir_filter_31_tap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_31_tap - direct-form FIR filter, 31 fixed Q1.15 taps
// Input gain, circular delay line, one shared MAC for all taps, output gain and
// saturation to a signed sample.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_        in   s_valid / s_ready    s_sample_in  (signed, SAMPLE_WIDTH)
//  m_        out  m_valid / m_ready    m_sample_out (signed, SAMPLE_WIDTH)
//  cfg_      in   cfg_wr_en            cfg_index, cfg_wdata (Q8.8 gains)
//
//  Each sample runs through the single MAC, which walks the delay line RAM
//  one entry a cycle.
//  A new sample is taken once the previous one has reached the result
//  register; a stalled result only holds the block when it is done again.
//  Reset clears the gains to 1.0, the write pointer and the delay line
//  valid bits, so the delay line reads as zero straight out of reset.
// ----------------------------------------------------------------------------
module fir_filter_31_tap
    import fir_pkg::*;
#(
    parameter int TAPS         = DEF_TAPS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [GAIN_W-1:0]              cfg_wdata,
    input  wire logic                           s_valid,
    output      logic                           s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample_in,
    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output      logic signed [SAMPLE_WIDTH-1:0] m_sample_out
);

    fir_cmd_t cmd;
    fir_sts_t sts;

    fir_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fir_dp #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cmd          (cmd),
        .sts          (sts)
    );

    // result register never overwritten while a beat is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register loaded while holding an untaken beat");

    // one sample in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a sample is in flight");

    // a result only appears from a load by the sequencer
    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("m_valid rose without a result load");

    // MAC reads only while no new sample can enter
    a_mac_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> !s_ready)
        else $error("delay line read while idle");

endmodule

`default_nettype wire

>>> verif/tb_fir_filter_31_tap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_filter_31_tap - self-checking bench for the 31-tap FIR filter
// Drives samples through the valid/ready input channel. A scoreboard class
// keeps its own gains, delay line and coefficient table, and predicts each
// filtered sample. Every output beat is checked against the oldest
// prediction. Phases change the gains while the block is idle and vary
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_fir_filter_31_tap;
    import fir_pkg::*;

    localparam int NTAPS = 31;
    localparam int SW    = DEF_SAMPLE_WIDTH;
    localparam int TAIL  = 60;   // settle time after the last expected beat is out

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam longint ACC_TOP = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam longint ACC_BOT = -ACC_TOP - 64'sd1;

    // Q1.15 taps, rounded from the real filter
    localparam int TAP_COEF [NTAPS] = '{
        16, 187, 2, 169, 685, -609, -2570, -458, 3137, 1641, -537, 1632, -672,
        -8234, -4187, 9879, 9879, -4187, -8234, -672, 1632, -537, 1641, 3137,
        -458, -2570, -609, 685, 169, 2, 187
    };

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    class fir_tracker;
        int unsigned errors;
        longint line_mem [NTAPS];
        int unsigned wr_ptr;
        logic [GAIN_W-1:0] gain_in;
        logic [GAIN_W-1:0] gain_out;
        logic signed [SW-1:0] expected_out [$];

        function new();
            errors = 0;
            wr_ptr = 0;
            gain_in = 16'd256;
            gain_out = 16'd256;
            foreach (line_mem[i]) line_mem[i] = 0;
        endfunction

        task report(string msg);
            $display("ERROR %0t: %s", $realtime, msg);
            errors++;
        endtask

        function longint clip_sample(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
            case (idx)
                REG_INPUT_GAIN:  gain_in = val;
                REG_OUTPUT_GAIN: gain_out = val;
                default: ;   // spare indexes are ignored
            endcase
        endfunction

        function logic signed [SW-1:0] filter_sample(logic signed [SW-1:0] x);
            longint s, g, acc, y;
            s = x;
            g = gain_in;
            wr_ptr = (wr_ptr == 0) ? NTAPS - 1 : wr_ptr - 1;
            line_mem[wr_ptr] = clip_sample((s * g + 64'sd128) >>> 8);
            acc = 0;
            for (int i = 0; i < NTAPS; i++) begin
                acc += longint'(TAP_COEF[i]) * line_mem[(wr_ptr + i) % NTAPS];
            end
            if (acc > ACC_TOP) acc = ACC_TOP;
            if (acc < ACC_BOT) acc = ACC_BOT;
            g = gain_out;
            y = (acc * g + (64'sd1 <<< 22)) >>> 23;
            y = clip_sample(y);
            return y[SW-1:0];
        endfunction

        function void take_sample(logic signed [SW-1:0] x);
            expected_out.push_back(filter_sample(x));
        endfunction

        task check_sample(logic signed [SW-1:0] got);
            logic signed [SW-1:0] want;
            if (expected_out.size() == 0) begin
                report($sformatf("output beat %0d with nothing pending", got));
            end else begin
                want = expected_out.pop_front();
                if (got !== want)
                    report($sformatf("sample_out got %0d want %0d", got, want));
            end
        endtask

        function int pending();
            return expected_out.size();
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [GAIN_W-1:0]       cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [SW-1:0]    s_sample_in = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [SW-1:0]    m_sample_out;

    fir_tracker sb = new();
    int send_pct = 0;
    int recv_pct = 0;
    logic signed [SW-1:0] last_sample = '0;

    fir_filter_31_tap u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_sample(m_sample_out);
        end
    end

    initial begin
        #20_000_000;
        $display("tb_fir_filter_31_tap: FAIL");
        $finish;
    end

    task set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
            IDLE_SEND: begin send_pct = 77; recv_pct = 0;  end
            IDLE_RECV: begin send_pct = 0;  recv_pct = 77; end
            IDLE_BOTH: begin send_pct = 22; recv_pct = 22; end
            default:   begin send_pct = 0;  recv_pct = 0;  end
        endcase
    endtask

    task wait_drained();
        while (sb.pending() != 0) @(negedge aclk);
        repeat (TAIL) @(negedge aclk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task set_gains(logic [GAIN_W-1:0] gin, logic [GAIN_W-1:0] gout);
        write_reg(REG_INPUT_GAIN, gin);
        write_reg(REG_OUTPUT_GAIN, gout);
    endtask

    // one input beat, with a random gap in front of it
    task push_sample(logic signed [SW-1:0] v);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_pct) gap++;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_sample_in = v;
        do @(posedge aclk); while (!s_ready);
        sb.take_sample(v);
        @(negedge aclk);
    endtask

    function logic signed [SW-1:0] pick_sample();
        int r;
        r = $urandom_range(9);
        case (r)
            0, 1, 2, 3: last_sample = SW'($urandom);
            4, 5:       last_sample = SW'($signed($urandom_range(512)) - 256);
            6:          last_sample = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            7:          ;   // repeat the last value, builds up long runs
            default:    last_sample = SW'($signed($urandom_range(8192)) - 4096);
        endcase
        return last_sample;
    endfunction

    task run_phase(idle_mode_t mode, int n);
        set_idle(mode);
        repeat (n) push_sample(pick_sample());
        s_valid = 1'b0;
    endtask

    initial begin
        logic signed [SW-1:0] directed [25];
        directed = '{default: 16'sd0};
        directed[0] = -16'sd32768;
        directed[1] = -16'sd1;
        directed[2] = 16'sd1;
        directed[3] = 16'sh5555;
        directed[4] = 16'shAAAA;
        directed[5] = 16'sd32767;   // impulse, then zeros walk it down the taps

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset gains, no idling
        set_idle(IDLE_NONE);
        foreach (directed[i]) push_sample(directed[i]);
        s_valid = 1'b0;
        run_phase(IDLE_NONE, 105);

        set_gains(16'hFFFF, 16'hFFFF);
        run_phase(IDLE_SEND, 130);

        set_gains(16'h0000, 16'd256);
        run_phase(IDLE_RECV, 80);

        set_gains(16'd256, 16'h0000);
        write_reg(REG_SPARE_A, GAIN_W'($urandom));
        write_reg(REG_SPARE_B, GAIN_W'($urandom));
        run_phase(IDLE_BOTH, 130);

        set_gains(16'hFFFF, 16'd256);
        run_phase(IDLE_NONE, 130);

        set_gains(GAIN_W'($urandom), GAIN_W'($urandom));
        run_phase(IDLE_SEND, 130);

        set_gains(16'd128, 16'd512);
        run_phase(IDLE_RECV, 130);

        set_gains(GAIN_W'($urandom), GAIN_W'($urandom));
        run_phase(IDLE_BOTH, 130);

        set_gains(16'd1, 16'hFFFF);
        run_phase(IDLE_NONE, 60);

        wait_drained();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected samples never came out", sb.pending()));
        if (sb.errors == 0) begin
            $display("tb_fir_filter_31_tap: PASS");
        end else begin
            $display("tb_fir_filter_31_tap: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
src/fir_pkg.sv
src/fir_ram.sv
src/fir_ctrl.sv
src/fir_dp.sv
src/fir_filter_31_tap.sv
verif/tb_fir_filter_31_tap.sv
